>>> rtl/ilcp_pkg.sv
// Shared types, constants and character tables for the line command parser.
// Used by every module of the block; depends on nothing.
package ilcp_pkg;

  localparam int LINE_CAPACITY_DEF = 128;
  localparam int NUM_WORDS         = 5;

  localparam logic [6:0] DRIVE_SPEED_RESET = 7'd80;
  localparam logic [6:0] SPEED_MAX         = 7'd100;

  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_M     = 8'h6D;

  localparam logic [2:0] IPD_LAST = 3'd4;
  localparam logic [2:0] MSG_LAST = 3'd3;

  localparam logic [2:0] CMD_UNKNOWN = 3'd0;
  localparam logic [2:0] CMD_FORWARD = 3'd1;
  localparam logic [2:0] CMD_BACK    = 3'd2;
  localparam logic [2:0] CMD_LEFT    = 3'd3;
  localparam logic [2:0] CMD_RIGHT   = 3'd4;
  localparam logic [2:0] CMD_STOP    = 3'd5;

  typedef struct packed {
    logic [2:0]        command_code;
    logic signed [7:0] left_speed;
    logic signed [7:0] right_speed;
    logic              enter_remote_mode;
  } result_t;

  function automatic logic [7:0] ipd_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = "+";
      3'd1:    c = "I";
      3'd2:    c = "P";
      3'd3:    c = "D";
      3'd4:    c = ",";
      default: c = CHAR_NUL;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] msg_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = "m";
      3'd1:    c = "s";
      3'd2:    c = "g";
      3'd3:    c = "=";
      default: c = CHAR_NUL;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] word_len(input logic [2:0] k);
    logic [2:0] n;
    case (k)
      3'd0:    n = 3'd7;
      3'd1:    n = 3'd4;
      3'd2:    n = 3'd4;
      3'd3:    n = 3'd5;
      3'd4:    n = 3'd4;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  // Character at position pos of keyword k, first character in the top byte.
  function automatic logic [7:0] word_char(input logic [2:0] k, input logic [2:0] pos);
    logic [55:0] txt;
    logic [7:0]  c;
    case (k)
      3'd0:    txt = "forward";
      3'd1:    txt = {"back", 24'h0};
      3'd2:    txt = {"left", 24'h0};
      3'd3:    txt = {"right", 16'h0};
      3'd4:    txt = {"stop", 24'h0};
      default: txt = '0;
    endcase
    if (pos == 3'd7) begin
      c = CHAR_NUL;
    end else begin
      c = txt[8 * (6 - int'(pos)) +: 8];
    end
    return c;
  endfunction

endpackage

>>> rtl/ilcp_line_parser.sv
// Per-line parse state: marker search, keyword match and result decode.
// Depends on ilcp_pkg.
module ilcp_line_parser #(
  parameter int LINE_CAPACITY = ilcp_pkg::LINE_CAPACITY_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  logic [7:0]            rx_byte_i,
  input  logic [6:0]            drive_speed_i,
  output logic                  res_valid_o,
  output ilcp_pkg::result_t     res_o
);

  localparam int CNT_W = $clog2(LINE_CAPACITY);
  localparam logic [CNT_W-1:0] KEPT_MAX = CNT_W'(LINE_CAPACITY - 1);

  typedef enum logic [1:0] {
    PH_IPD,
    PH_COLON,
    PH_MSG,
    PH_WORD
  } phase_e;

  phase_e                        phase_q, phase_d;
  logic [CNT_W-1:0]              kept_q, kept_d;
  logic [2:0]                    idx_q, idx_d;
  logic [ilcp_pkg::NUM_WORDS-1:0] alive_q, alive_d;
  logic [2:0]                    pos_q, pos_d;
  logic                          ended_q, ended_d;

  logic       is_lf;
  logic       found;
  logic [2:0] code;
  logic [6:0] speed;
  logic [7:0] spd_pos;
  logic [7:0] spd_neg;
  logic [7:0] ls;
  logic [7:0] rs;

  assign is_lf = (rx_byte_i == ilcp_pkg::CHAR_LF);

  // Next line state for one byte.
  always_comb begin
    phase_d = phase_q;
    kept_d  = kept_q;
    idx_d   = idx_q;
    alive_d = alive_q;
    pos_d   = pos_q;
    ended_d = ended_q;
    if (is_lf) begin
      phase_d = PH_IPD;
      kept_d  = '0;
      idx_d   = '0;
      alive_d = '1;
      pos_d   = '0;
      ended_d = 1'b0;
    end else if (rx_byte_i != ilcp_pkg::CHAR_CR && kept_q != KEPT_MAX) begin
      kept_d = kept_q + 1'b1;
      if (!ended_q) begin
        if (rx_byte_i == ilcp_pkg::CHAR_NUL) begin
          ended_d = 1'b1;
        end else begin
          case (phase_q)
            PH_IPD: begin
              if (rx_byte_i == ilcp_pkg::ipd_char(idx_q)) begin
                if (idx_q == ilcp_pkg::IPD_LAST) begin
                  phase_d = PH_COLON;
                  idx_d   = '0;
                end else begin
                  idx_d = idx_q + 1'b1;
                end
              end else begin
                idx_d = (rx_byte_i == ilcp_pkg::CHAR_PLUS) ? 3'd1 : 3'd0;
              end
            end
            PH_COLON: begin
              if (rx_byte_i == ilcp_pkg::CHAR_COLON) begin
                phase_d = PH_MSG;
                idx_d   = '0;
              end
            end
            PH_MSG: begin
              if (rx_byte_i == ilcp_pkg::msg_char(idx_q)) begin
                if (idx_q == ilcp_pkg::MSG_LAST) begin
                  phase_d = PH_WORD;
                  idx_d   = '0;
                end else begin
                  idx_d = idx_q + 1'b1;
                end
              end else begin
                idx_d = (rx_byte_i == ilcp_pkg::CHAR_M) ? 3'd1 : 3'd0;
              end
            end
            default: begin
              for (int k = 0; k < ilcp_pkg::NUM_WORDS; k++) begin
                if (!(pos_q < ilcp_pkg::word_len(3'(k)) &&
                      rx_byte_i == ilcp_pkg::word_char(3'(k), pos_q))) begin
                  alive_d[k] = 1'b0;
                end
              end
              if (pos_q != 3'd7) begin
                pos_d = pos_q + 1'b1;
              end
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IPD;
      kept_q  <= '0;
      idx_q   <= '0;
      alive_q <= '1;
      pos_q   <= '0;
      ended_q <= 1'b0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      kept_q  <= kept_d;
      idx_q   <= idx_d;
      alive_q <= alive_d;
      pos_q   <= pos_d;
      ended_q <= ended_d;
    end
  end

  // Pick the first keyword that matched in full.
  always_comb begin
    found = 1'b0;
    code  = ilcp_pkg::CMD_UNKNOWN;
    for (int k = 0; k < ilcp_pkg::NUM_WORDS; k++) begin
      if (!found && alive_q[k] && pos_q == ilcp_pkg::word_len(3'(k))) begin
        found = 1'b1;
        code  = 3'(k + 1);
      end
    end
  end

  assign speed   = (drive_speed_i > ilcp_pkg::SPEED_MAX) ? ilcp_pkg::SPEED_MAX : drive_speed_i;
  assign spd_pos = {1'b0, speed};
  assign spd_neg = 8'(~spd_pos + 8'd1);

  always_comb begin
    case (code)
      ilcp_pkg::CMD_FORWARD: begin ls = spd_pos; rs = spd_pos; end
      ilcp_pkg::CMD_BACK:    begin ls = spd_neg; rs = spd_neg; end
      ilcp_pkg::CMD_LEFT:    begin ls = spd_neg; rs = spd_pos; end
      ilcp_pkg::CMD_RIGHT:   begin ls = spd_pos; rs = spd_neg; end
      default:               begin ls = '0;      rs = '0;      end
    endcase
  end

  assign res_valid_o             = is_lf && kept_q != '0 && phase_q == PH_WORD;
  assign res_o.command_code      = code;
  assign res_o.left_speed        = $signed(ls);
  assign res_o.right_speed       = $signed(rs);
  assign res_o.enter_remote_mode = 1'b1;

endmodule

>>> rtl/ilcp_result_reg.sv
// Result register: holds one decoded command beat until the sink takes it.
// Depends on ilcp_pkg.
module ilcp_result_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  logic              res_valid_i,
  input  ilcp_pkg::result_t res_i,
  input  logic              out_stall_i,
  output logic              advance_o,
  output logic              out_valid_o,
  output ilcp_pkg::result_t res_o
);

  logic              valid_q;
  ilcp_pkg::result_t res_q;

  // Move on when the register is empty or its beat leaves this cycle.
  assign advance_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_o) begin
      valid_q <= load_i && res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && load_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

>>> rtl/ipd_line_command_parser_unit.sv
// Top level of the line command parser: byte register, config register,
// line parser and result register. Depends on ilcp_pkg, ilcp_line_parser, ilcp_result_reg.
//
//  port group      dir  handshake                 payload
//  rx byte in      in   in_valid_i / in_stall_o   rx_byte_i[7:0]
//  command out     out  out_valid_o / out_stall_i command_code_o, left_speed_o,
//                                                 right_speed_o, enter_remote_mode_o
//  config write    in   cfg_valid_i / cfg_ready_o cfg_drive_speed_i[6:0]
//
// One byte per cycle while no command beat is stalled. A byte is registered on
// accept and parsed from there; a newline's command beat is registered as it is parsed.
// Reset clears the line state and sets drive speed to 80.
// A stalled command beat holds; a byte waiting behind it holds and stalls input.
module ipd_line_command_parser_unit #(
  parameter int LINE_CAPACITY = ilcp_pkg::LINE_CAPACITY_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        rx_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [2:0]        command_code_o,
  output logic signed [7:0] left_speed_o,
  output logic signed [7:0] right_speed_o,
  output logic              enter_remote_mode_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [6:0]        cfg_drive_speed_i
);

  logic              proc_valid_q;
  logic [7:0]        proc_byte_q;
  logic [6:0]        drive_speed_q;
  logic              advance;
  logic              fire;
  logic              res_valid;
  ilcp_pkg::result_t res;
  ilcp_pkg::result_t res_out;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = proc_valid_q && !advance;
  assign fire        = proc_valid_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_speed_q <= ilcp_pkg::DRIVE_SPEED_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      drive_speed_q <= cfg_drive_speed_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proc_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      proc_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      proc_byte_q <= rx_byte_i;
    end
  end

  ilcp_line_parser #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .rx_byte_i    (proc_byte_q),
    .drive_speed_i(drive_speed_q),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  ilcp_result_reg u_result (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (proc_valid_q),
    .res_valid_i(res_valid),
    .res_i      (res),
    .out_stall_i(out_stall_i),
    .advance_o  (advance),
    .out_valid_o(out_valid_o),
    .res_o      (res_out)
  );

  assign command_code_o      = res_out.command_code;
  assign left_speed_o        = res_out.left_speed;
  assign right_speed_o       = res_out.right_speed;
  assign enter_remote_mode_o = res_out.enter_remote_mode;

`ifndef NO_ASSERTIONS
  a_result_after_newline: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(fire && proc_byte_q == ilcp_pkg::CHAR_LF))
    else $error("command beat without a parsed newline");

  a_remote_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> enter_remote_mode_o)
    else $error("command beat without remote request");

  a_idle_speeds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (command_code_o == ilcp_pkg::CMD_UNKNOWN ||
                    command_code_o == ilcp_pkg::CMD_STOP)
    |-> left_speed_o == 8'sd0 && right_speed_o == 8'sd0)
    else $error("nonzero speed on stop or unknown word");
`endif

endmodule
